### src/psg_pkg.sv
// Shared types, constants and the amplitude table of the three-voice sound generator.
// Used by psg_front, psg_back and the top level; no dependencies of its own.
package psg_pkg;

    localparam int DIV_W      = 5;
    localparam int VOICE_W    = 23;
    localparam int NPER_W     = 16;
    localparam int EPER_W     = 21;
    localparam int SHAPE_W    = 4;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int MIN_W      = 10;
    localparam int SAMPLE_W   = 15;
    localparam int CLK_W      = 11;
    localparam int STEP_W     = 9;
    localparam int AMP_W      = 14;
    localparam int TONE_CNT_W = 18;
    localparam int NOISE_W    = 17;
    localparam int ENV_CNT_W  = 23;

    localparam int MAX_SAMPLES     = 64;
    localparam int CNT_W           = $clog2(MAX_SAMPLES);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [DIV_W-1:0]   DIVISOR_RST   = 5'd8;
    localparam logic [VOICE_W-1:0] VOICE_RST     = 23'h001000;
    localparam logic [NPER_W-1:0]  NOISE_PER_RST = 16'h0040;
    localparam logic [EPER_W-1:0]  ENV_PER_RST   = 21'h020000;

    localparam logic signed [TONE_CNT_W-1:0] TONE_CNT_RST  = 18'sh01000;
    localparam logic signed [TONE_CNT_W-1:0] NOISE_CNT_RST = 18'sh00040;
    localparam logic signed [ENV_CNT_W-1:0]  ENV_CNT_RST   = 23'sh020000;
    localparam logic [NOISE_W-1:0]           NOISE_TAPS    = 17'h14000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIVISOR,
        REG_VOICE_A,
        REG_VOICE_B,
        REG_VOICE_C,
        REG_NOISE_PER,
        REG_ENV_PER,
        REG_ENV_SHAPE,
        REG_NOISE_EN
    } cfg_reg_t;

    typedef struct packed {
        logic [DIV_W-1:0]              divisor;
        logic [2:0][VOICE_W-1:0]       voice;
        logic [NPER_W-1:0]             noise_period;
        logic [EPER_W-1:0]             env_period;
        logic [SHAPE_W-1:0]            env_shape;
        logic                          noise_en;
    } cfg_t;

    typedef struct packed {
        logic go;
        logic attack;
    } env_restart_t;

    // one queued request: clock target and master clocks per sample
    typedef struct packed {
        logic [MIN_W-1:0]  min_clocks;
        logic [STEP_W-1:0] step;
    } req_t;

    function automatic logic [DIV_W-1:0] eff_divisor(input logic [DIV_W-1:0] d);
        return (d == '0) ? DIV_W'(1) : d;
    endfunction

    // logarithmic volume to amplitude
    function automatic logic [AMP_W-1:0] amp_lookup(input logic [3:0] vol);
        logic [AMP_W-1:0] a;
        case (vol)
            4'd0:    a = 14'h003C;
            4'd1:    a = 14'h0055;
            4'd2:    a = 14'h0079;
            4'd3:    a = 14'h00AB;
            4'd4:    a = 14'h00F1;
            4'd5:    a = 14'h0155;
            4'd6:    a = 14'h01E3;
            4'd7:    a = 14'h02AA;
            4'd8:    a = 14'h03C5;
            4'd9:    a = 14'h0555;
            4'd10:   a = 14'h078B;
            4'd11:   a = 14'h0AAB;
            4'd12:   a = 14'h0F16;
            4'd13:   a = 14'h1555;
            4'd14:   a = 14'h1E2B;
            default: a = 14'h2AAA;
        endcase
        return a;
    endfunction

endpackage

### src/psg_fifo.sv
// Small request queue between the front and back parts of the sound generator.
// Depends on nothing; width and depth come from parameters.
module psg_fifo #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign ready    = (fill_reg != CNT_W'(DEPTH));
    assign valid    = (fill_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && ready;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/psg_front.sv
// Front part: takes request transfers, works out the per-sample clock step, queues them.
// Depends on psg_pkg.
module psg_front
    import psg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIV_W-1:0] divisor,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [MIN_W-1:0] min_clocks,
    output logic             q_push,
    output req_t             q_data,
    input  logic             q_ready
);

    logic hold_valid_reg, hold_valid_next;
    req_t hold_reg, hold_next;
    logic accept;

    assign in_stall = hold_valid_reg && !q_ready;
    assign accept   = in_valid && !in_stall;
    assign q_push   = hold_valid_reg;
    assign q_data   = hold_reg;

    always_comb
    begin
        hold_valid_next = accept || (hold_valid_reg && !q_ready);
        hold_next       = hold_reg;
        if (accept)
        begin
            hold_next.min_clocks = min_clocks;
            hold_next.step       = {eff_divisor(divisor), 4'b0000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

### src/psg_back.sv
// Back part: sample engine with envelope, noise and tone generators and the mixer.
// Pops requests from the queue and drives the output register. Depends on psg_pkg.
module psg_back
    import psg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  env_restart_t        restart,
    input  logic                q_valid,
    input  req_t                q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SAMPLE_W-1:0] sample,
    output logic                last_sample,
    output logic [CLK_W-1:0]    clocks_used
);

    typedef enum logic [1:0] {ST_IDLE, ST_SUB, ST_ARM, ST_MIX} state_t;

    typedef struct packed {
        logic [3:0] level;
        logic       idle;
        logic       rising;
    } env_t;

    function automatic env_t env_step(input env_t cur, input logic [SHAPE_W-1:0] shape);
        env_t nxt;
        logic wrap;
        nxt  = cur;
        wrap = cur.rising ? (cur.level == 4'hF) : (cur.level == 4'h0);
        if (!cur.idle)
        begin
            if (!wrap)
            begin
                nxt.level = cur.rising ? cur.level + 4'd1 : cur.level - 4'd1;
            end
            else if (!shape[3])
            begin
                nxt.level = 4'h0;
                nxt.idle  = 1'b1;
            end
            else if (shape[0])
            begin
                nxt.level = (cur.rising == shape[1]) ? 4'h0 : 4'hF;
                nxt.idle  = 1'b1;
            end
            else
            begin
                nxt.rising = cur.rising ^ shape[1];
                nxt.level  = nxt.rising ? 4'h0 : 4'hF;
            end
        end
        return nxt;
    endfunction

    state_t                        state_reg, state_next;
    req_t                          req_reg, req_next;
    logic [CLK_W-1:0]              total_reg, total_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic signed [ENV_CNT_W-1:0]   env_cnt_reg, env_cnt_next;
    env_t                          env_reg, env_next;
    logic signed [TONE_CNT_W-1:0]  noise_cnt_reg, noise_cnt_next;
    logic [NOISE_W-1:0]            noise_shift_reg, noise_shift_next;
    logic                          noise_bit_reg, noise_bit_next;
    logic signed [TONE_CNT_W-1:0]  tone_cnt_reg [3];
    logic signed [TONE_CNT_W-1:0]  tone_cnt_next [3];
    logic [2:0]                    tone_lvl_reg, tone_lvl_next;
    logic                          out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]           sample_reg, sample_next;
    logic                          last_reg, last_next;
    logic [CLK_W-1:0]              clocks_reg, clocks_next;

    logic [DIV_W-1:0]  div;
    logic [EPER_W-1:0] env_per;
    logic [NPER_W-1:0] noise_per;
    logic [NPER_W-1:0] tone_per [3];
    logic              env_due, noise_due;
    logic [2:0]        tone_due;
    logic [SAMPLE_W-1:0] mix_sum;
    logic [3:0]        vol;
    logic              gate;
    logic [CLK_W-1:0]  total_sum;
    logic              is_last;
    logic              out_free;

    assign div       = eff_divisor(cfg.divisor);
    assign env_per   = (cfg.env_period == '0) ? EPER_W'(1) : cfg.env_period;
    assign noise_per = (cfg.noise_period == '0) ? NPER_W'(1) : cfg.noise_period;
    assign env_due   = env_cnt_reg[ENV_CNT_W-1] || (env_cnt_reg == '0);
    assign noise_due = noise_cnt_reg[TONE_CNT_W-1] || (noise_cnt_reg == '0);
    assign out_free  = !out_valid_reg || !out_stall;
    assign total_sum = total_reg + CLK_W'(req_reg.step);
    assign is_last   = (total_sum >= CLK_W'(req_reg.min_clocks))
                       || (count_reg == CNT_W'(MAX_SAMPLES - 1));

    assign q_pop       = (state_reg == ST_IDLE) && q_valid;
    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign last_sample = last_reg;
    assign clocks_used = clocks_reg;

    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            tone_per[v] = (cfg.voice[v][15:0] == '0) ? NPER_W'(1) : cfg.voice[v][15:0];
            tone_due[v] = tone_cnt_reg[v][TONE_CNT_W-1] || (tone_cnt_reg[v] == '0);
        end
    end

    // mixer: gate each voice, pick volume, map and add
    always_comb
    begin
        mix_sum = '0;
        vol     = '0;
        gate    = 1'b0;
        for (int v = 0; v < 3; v++)
        begin
            gate = (cfg.voice[v][21] | tone_lvl_reg[v]) & (cfg.voice[v][22] | noise_bit_reg);
            vol  = !gate ? 4'h0 : (cfg.voice[v][20] ? env_reg.level : cfg.voice[v][19:16]);
            mix_sum = mix_sum + SAMPLE_W'(amp_lookup(vol));
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        total_next       = total_reg;
        count_next       = count_reg;
        env_cnt_next     = env_cnt_reg;
        env_next         = env_reg;
        noise_cnt_next   = noise_cnt_reg;
        noise_shift_next = noise_shift_reg;
        noise_bit_next   = noise_bit_reg;
        tone_cnt_next    = tone_cnt_reg;
        tone_lvl_next    = tone_lvl_reg;
        out_valid_next   = out_valid_reg;
        sample_next      = sample_reg;
        last_next        = last_reg;
        clocks_next      = clocks_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    req_next   = q_data;
                    total_next = '0;
                    count_next = '0;
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                env_cnt_next   = env_cnt_reg - $signed(ENV_CNT_W'(div));
                noise_cnt_next = noise_cnt_reg - $signed(TONE_CNT_W'(div));
                for (int v = 0; v < 3; v++)
                begin
                    tone_cnt_next[v] = tone_cnt_reg[v] - $signed(TONE_CNT_W'(div));
                end
                state_next = ST_ARM;
            end
            ST_ARM:
            begin
                // one re-arm addition per counter per cycle until all are positive
                if (env_due)
                begin
                    env_cnt_next = env_cnt_reg + $signed(ENV_CNT_W'(env_per));
                    env_next     = env_step(env_reg, cfg.env_shape);
                end
                if (noise_due)
                begin
                    noise_cnt_next = noise_cnt_reg + $signed(TONE_CNT_W'(noise_per));
                    if (cfg.noise_en)
                    begin
                        noise_shift_next = (noise_shift_reg >> 1)
                                           ^ (noise_bit_reg ? NOISE_TAPS : '0);
                        noise_bit_next   = noise_shift_next[0];
                    end
                end
                for (int v = 0; v < 3; v++)
                begin
                    if (tone_due[v])
                    begin
                        tone_cnt_next[v] = tone_cnt_reg[v] + $signed(TONE_CNT_W'(tone_per[v]));
                        tone_lvl_next[v] = ~tone_lvl_reg[v];
                    end
                end
                if (!env_due && !noise_due && (tone_due == '0))
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = mix_sum;
                    last_next      = is_last;
                    clocks_next    = total_sum;
                    total_next     = total_sum;
                    count_next     = count_reg + CNT_W'(1);
                    state_next     = is_last ? ST_IDLE : ST_SUB;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // shape write restarts the envelope
        if (restart.go)
        begin
            env_next.rising = restart.attack;
            env_next.level  = restart.attack ? 4'h0 : 4'hF;
            env_next.idle   = 1'b0;
            env_cnt_next    = $signed(ENV_CNT_W'(env_per));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            req_reg         <= '0;
            total_reg       <= '0;
            count_reg       <= '0;
            env_cnt_reg     <= ENV_CNT_RST;
            env_reg         <= '{level: 4'h0, idle: 1'b1, rising: 1'b0};
            noise_cnt_reg   <= NOISE_CNT_RST;
            noise_shift_reg <= NOISE_W'(1);
            noise_bit_reg   <= 1'b1;
            for (int v = 0; v < 3; v++)
            begin
                tone_cnt_reg[v] <= TONE_CNT_RST;
            end
            tone_lvl_reg    <= '0;
            out_valid_reg   <= 1'b0;
            sample_reg      <= '0;
            last_reg        <= 1'b0;
            clocks_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            req_reg         <= req_next;
            total_reg       <= total_next;
            count_reg       <= count_next;
            env_cnt_reg     <= env_cnt_next;
            env_reg         <= env_next;
            noise_cnt_reg   <= noise_cnt_next;
            noise_shift_reg <= noise_shift_next;
            noise_bit_reg   <= noise_bit_next;
            tone_cnt_reg    <= tone_cnt_next;
            tone_lvl_reg    <= tone_lvl_next;
            out_valid_reg   <= out_valid_next;
            sample_reg      <= sample_next;
            last_reg        <= last_next;
            clocks_reg      <= clocks_next;
        end
    end

endmodule

### src/psg_three_tone_noise_envelope.sv
// Top level of the three-voice sound generator: configuration registers,
// front part, request queue and sample engine. Depends on psg_pkg, psg_front,
// psg_fifo and psg_back.
//
// Usage: each input transfer carries min_clocks, the number of master clocks
// to cover. The block answers with one or more sample transfers, each covering
// 16 x clock_divisor master clocks; clocks_used gives the running total and
// last_sample marks the final sample of the request. Configuration is written
// through cfg_write / cfg_index / cfg_data while no request is in flight;
// writing the envelope shape restarts the envelope.
// Timing: an accepted input transfer is registered in the front part, then
// written into the queue, and the engine pops it while idle. Each sample then
// passes through ST_SUB, ST_ARM and ST_MIX, where ST_ARM repeats until no
// counter needs another re-arm addition (at most the divisor of them, so at
// most 31); all five counters re-arm in parallel, one addition a cycle, and
// ST_MIX waits while the output is stalled. The engine takes the next request
// from the queue only after the last sample of the current one.
// Reset puts the configuration registers and generators at their power-up values, with an
// empty queue and no pending output. A stalled output holds its sample; the
// engine waits for it, the queue fills, and then in_stall rises.
module psg_three_tone_noise_envelope
    import psg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [MIN_W-1:0]      min_clocks,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SAMPLE_W-1:0]   sample,
    output logic                  last_sample,
    output logic [CLK_W-1:0]      clocks_used
);

    cfg_t         cfg_reg, cfg_next;
    env_restart_t restart;
    logic         q_push, q_ready, q_pop, q_valid;
    req_t         q_in, q_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DIVISOR:   cfg_next.divisor      = cfg_data[DIV_W-1:0];
                REG_VOICE_A:   cfg_next.voice[0]     = cfg_data[VOICE_W-1:0];
                REG_VOICE_B:   cfg_next.voice[1]     = cfg_data[VOICE_W-1:0];
                REG_VOICE_C:   cfg_next.voice[2]     = cfg_data[VOICE_W-1:0];
                REG_NOISE_PER: cfg_next.noise_period = cfg_data[NPER_W-1:0];
                REG_ENV_PER:   cfg_next.env_period   = cfg_data[EPER_W-1:0];
                REG_ENV_SHAPE: cfg_next.env_shape    = cfg_data[SHAPE_W-1:0];
                REG_NOISE_EN:  cfg_next.noise_en     = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    assign restart.go     = cfg_write && (cfg_reg_t'(cfg_index) == REG_ENV_SHAPE);
    assign restart.attack = cfg_data[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.divisor      <= DIVISOR_RST;
            cfg_reg.voice        <= {VOICE_RST, VOICE_RST, VOICE_RST};
            cfg_reg.noise_period <= NOISE_PER_RST;
            cfg_reg.env_period   <= ENV_PER_RST;
            cfg_reg.env_shape    <= '0;
            cfg_reg.noise_en     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    psg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .divisor    (cfg_reg.divisor),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .min_clocks (min_clocks),
        .q_push     (q_push),
        .q_data     (q_in),
        .q_ready    (q_ready)
    );

    psg_fifo #(
        .WIDTH ($bits(req_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    psg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .restart     (restart),
        .q_valid     (q_valid),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample),
        .last_sample (last_sample),
        .clocks_used (clocks_used)
    );

endmodule
